// File: src/i2cmfs_pkg.sv
package i2cmfs_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;

    localparam logic [7:0] ST_START    = 8'h08;
    localparam logic [7:0] ST_RESTART  = 8'h10;
    localparam logic [7:0] ST_ADDR_ACK = 8'h18;
    localparam logic [7:0] ST_DATA_ACK = 8'h28;

    localparam int HEADER_BYTES = 2;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_WRITE   = 3'd1,
        ACT_STOP    = 3'd2,
        ACT_RESTART = 3'd3,
        ACT_START   = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        CMD_PUSH,
        CMD_START,
        CMD_ADDR_ACK,
        CMD_DATA_ACK,
        CMD_ERROR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    typedef enum logic {
        BK_FETCH,
        BK_EXEC
    } back_state_t;

endpackage

// File: src/i2cmfs_if.sv
interface i2cmfs_req_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] push_byte;
    logic [7:0] bus_status;

    modport source (output valid, kind, push_byte, bus_status, input ready);
    modport sink (input valid, kind, push_byte, bus_status, output ready);
endinterface

interface i2cmfs_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] bus_action;
    logic [7:0] write_byte;
    logic       finished;
    logic [5:0] queue_fill;
    logic       push_dropped;
    logic       pop_underflow;

    modport source (output valid, bus_action, write_byte, finished, queue_fill,
                    push_dropped, pop_underflow, input ready);
    modport sink (input valid, bus_action, write_byte, finished, queue_fill,
                  push_dropped, pop_underflow, output ready);
endinterface

// File: src/i2cmfs_front.sv
module i2cmfs_front
    import i2cmfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    i2cmfs_req_if.sink req,
    output cmd_t       cmd,
    output logic       cmd_valid,
    input  logic       cmd_ready
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;
    cmd_t       cls;

    always_comb
    begin
        cls.data = req.push_byte;
        if (!req.kind)
        begin
            cls.kind = CMD_PUSH;
        end
        else
        begin
            case (req.bus_status)
                ST_START, ST_RESTART: cls.kind = CMD_START;
                ST_ADDR_ACK:          cls.kind = CMD_ADDR_ACK;
                ST_DATA_ACK:          cls.kind = CMD_DATA_ACK;
                default:              cls.kind = CMD_ERROR;
            endcase
        end
    end

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// File: src/i2cmfs_back.sv
module i2cmfs_back
    import i2cmfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cmd_t         cmd,
    input  logic         cmd_valid,
    output logic         cmd_ready,
    i2cmfs_res_if.source res
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [7:0]    mem [QUEUE_DEPTH];

    back_state_t   state_reg;
    back_state_t   state_next;
    cmd_t          cur_reg;
    logic [7:0]    rd0_reg;
    logic [7:0]    rd1_reg;

    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [AW-1:0] tail_reg;
    logic [AW-1:0] tail_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [7:0]    len_reg;
    logic [7:0]    len_next;
    logic [7:0]    sent_reg;
    logic [7:0]    sent_next;
    logic          done_reg;
    logic          done_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [2:0]    action_reg;
    logic [7:0]    wbyte_reg;
    logic          finished_reg;
    logic [5:0]    fill_reg;
    logic          dropped_reg;
    logic          underflow_reg;

    logic [AW-1:0] head_p1;
    logic [AW-1:0] head_p2;
    logic [AW-1:0] tail_p1;
    logic          fetch;
    logic          fire;
    logic          mem_we;
    action_t       act;
    logic [7:0]    wbyte;
    logic          dropped;
    logic          underflow;

    assign head_p1 = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_p2 = (head_p1 == AW'(QUEUE_DEPTH - 1)) ? '0 : head_p1 + 1'b1;
    assign tail_p1 = (tail_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    assign cmd_ready = (state_reg == BK_FETCH);
    assign fetch     = cmd_valid && cmd_ready;
    assign fire      = (state_reg == BK_EXEC) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_FETCH: if (cmd_valid) state_next = BK_EXEC;
            BK_EXEC:  if (fire) state_next = BK_FETCH;
            default:  state_next = BK_FETCH;
        endcase
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        len_next   = len_reg;
        sent_next  = sent_reg;
        done_next  = done_reg;
        act        = ACT_NONE;
        wbyte      = 8'd0;
        dropped    = 1'b0;
        underflow  = 1'b0;
        mem_we     = 1'b0;
        if (fire)
        begin
            case (cur_reg.kind)
                CMD_PUSH:
                begin
                    if (count_reg == CW'(QUEUE_DEPTH))
                    begin
                        dropped = 1'b1;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        tail_next  = tail_p1;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_START:
                begin
                    act       = ACT_WRITE;
                    done_next = 1'b0;
                    if (count_reg >= CW'(HEADER_BYTES))
                    begin
                        len_next   = rd0_reg;
                        wbyte      = rd1_reg;
                        head_next  = head_p2;
                        count_next = count_reg - CW'(HEADER_BYTES);
                    end
                    else if (count_reg != '0)
                    begin
                        len_next   = rd0_reg;
                        underflow  = 1'b1;
                        head_next  = head_p1;
                        count_next = '0;
                    end
                    else
                    begin
                        len_next  = 8'd0;
                        underflow = 1'b1;
                    end
                end
                CMD_ADDR_ACK:
                begin
                    act       = ACT_WRITE;
                    sent_next = 8'd1;
                    if (count_reg != '0)
                    begin
                        wbyte      = rd0_reg;
                        head_next  = head_p1;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        underflow = 1'b1;
                    end
                end
                CMD_DATA_ACK:
                begin
                    if (sent_reg < len_reg)
                    begin
                        act       = ACT_WRITE;
                        sent_next = sent_reg + 8'd1;
                        if (count_reg != '0)
                        begin
                            wbyte      = rd0_reg;
                            head_next  = head_p1;
                            count_next = count_reg - 1'b1;
                        end
                        else
                        begin
                            underflow = 1'b1;
                        end
                    end
                    else if (count_reg != '0 &&
                             ({2'b00, rd0_reg} + 10'(HEADER_BYTES)) <= 10'(count_reg))
                    begin
                        act = ACT_RESTART;
                    end
                    else
                    begin
                        act       = ACT_STOP;
                        done_next = 1'b1;
                    end
                end
                CMD_ERROR: act = ACT_START;
                default:   act = ACT_NONE;
            endcase
        end
    end

    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_FETCH;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            len_reg       <= 8'd0;
            sent_reg      <= 8'd0;
            done_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            len_reg       <= len_next;
            sent_reg      <= sent_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // byte store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg] <= cur_reg.data;
        end
        if (fetch)
        begin
            rd0_reg <= mem[head_reg];
            rd1_reg <= mem[head_p1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fetch)
        begin
            cur_reg <= cmd;
        end
        if (fire)
        begin
            action_reg    <= act;
            wbyte_reg     <= wbyte;
            finished_reg  <= done_next;
            fill_reg      <= 6'(count_next);
            dropped_reg   <= dropped;
            underflow_reg <= underflow;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.bus_action    = action_reg;
    assign res.write_byte    = wbyte_reg;
    assign res.finished      = finished_reg;
    assign res.queue_fill    = fill_reg;
    assign res.push_dropped  = dropped_reg;
    assign res.pop_underflow = underflow_reg;

endmodule

// File: src/i2c_master_frame_sequencer_core.sv
// channel  dir  payload                                             transfer when
// req      in   kind, push_byte, bus_status                         req.valid && req.ready
// res      out  bus_action, write_byte, finished, queue_fill,       res.valid && res.ready
//               push_dropped, pop_underflow
// The back end alternates fetch and execute around the registered byte-store read and
// takes no new command while executing one; results leave through a result register.
// Reset clears pointers, counters and flags at once; no clearing pass over the byte store.
// A 2-entry command queue and a result register let each side stall on its own.
module i2c_master_frame_sequencer_core
    import i2cmfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    i2cmfs_req_if.sink   req,
    i2cmfs_res_if.source res
);

    localparam logic [5:0] FULL_FILL = 6'(QUEUE_DEPTH);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    i2cmfs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    i2cmfs_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .res       (res)
    );

`ifndef NO_ASSERTIONS
    a_write_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.bus_action != ACT_WRITE |-> res.write_byte == 8'd0)
        else $error("write_byte set without write action");

    a_stop_finished: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.bus_action == ACT_STOP |-> res.finished)
        else $error("stop without finished flag");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.push_dropped |->
            res.bus_action == ACT_NONE && res.queue_fill == FULL_FILL)
        else $error("dropped push while queue not full");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.pop_underflow |->
            res.queue_fill == 6'd0 && res.bus_action == ACT_WRITE)
        else $error("underflow with bytes left");
`endif

endmodule

// File: bench/tb_i2c_master_frame_sequencer_core.sv
module tb_i2c_master_frame_sequencer_core;
    import i2cmfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int RAND_ITEMS = 900;
    localparam int HOLD_AT = 600;
    localparam int HOLD_LEN = 80;
    localparam int TAIL_ITEMS = 100;

    typedef struct packed {
        logic       kind;
        logic [7:0] push_byte;
        logic [7:0] bus_status;
    } bus_item_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] write_byte;
        logic       finished;
        logic [5:0] queue_fill;
        logic       push_dropped;
        logic       pop_underflow;
    } bus_result_t;

    logic clk;
    logic rst_n;

    i2cmfs_req_if req_ch();
    i2cmfs_res_if res_ch();

    i2c_master_frame_sequencer_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    bus_item_t   tx_items[$];
    bus_result_t pending_actions[$];
    bus_item_t   cur_item;

    // predictor state
    logic [7:0] byte_mem [0:DEPTH-1];
    int         rd_ptr;
    int         wr_ptr;
    int         fill_cnt;
    logic [7:0] frame_len;
    logic [7:0] sent_cnt;
    logic [7:0] last_sent;
    logic       done_bit;
    logic       pop_missed;

    int planned;
    int sent_items;
    int got_results;
    int fails;
    int n_writes;
    int n_stops;
    int n_restarts;
    int n_starts;
    int n_dropped;
    int n_underflow;

    logic [31:0] cyc_cnt;
    int          hold_left;
    logic        tail_phase;
    int          gap_left;
    int          stall_left;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [7:0] take_byte();
        logic [7:0] b;
        if (fill_cnt == 0) begin
            pop_missed = 1'b1;
            return 8'h00;
        end
        b = byte_mem[rd_ptr];
        rd_ptr = (rd_ptr + 1) % DEPTH;
        fill_cnt--;
        return b;
    endfunction

    function automatic bus_result_t next_bus_step(bus_item_t it);
        bus_result_t r;
        r.action = ACT_NONE;
        r.write_byte = 8'h00;
        r.push_dropped = 1'b0;
        pop_missed = 1'b0;
        if (!it.kind) begin
            if (fill_cnt >= DEPTH) begin
                r.push_dropped = 1'b1;
            end
            else begin
                byte_mem[wr_ptr] = it.push_byte;
                wr_ptr = (wr_ptr + 1) % DEPTH;
                fill_cnt++;
            end
        end
        else if (it.bus_status == ST_START || it.bus_status == ST_RESTART) begin
            frame_len = take_byte();
            last_sent = take_byte();
            done_bit = 1'b0;
            r.action = ACT_WRITE;
            r.write_byte = last_sent;
        end
        else if (it.bus_status == ST_ADDR_ACK) begin
            last_sent = take_byte();
            sent_cnt = 8'd1;
            r.action = ACT_WRITE;
            r.write_byte = last_sent;
        end
        else if (it.bus_status == ST_DATA_ACK) begin
            if (sent_cnt < frame_len) begin
                last_sent = take_byte();
                sent_cnt++;
                r.action = ACT_WRITE;
                r.write_byte = last_sent;
            end
            else if (fill_cnt != 0 && int'(byte_mem[rd_ptr]) + HEADER_BYTES <= fill_cnt) begin
                r.action = ACT_RESTART;
            end
            else begin
                r.action = ACT_STOP;
                done_bit = 1'b1;
            end
        end
        else begin
            r.action = ACT_START;
        end
        r.finished = done_bit;
        r.queue_fill = 6'(fill_cnt);
        r.pop_underflow = pop_missed;
        return r;
    endfunction

    task automatic add_push(logic [7:0] b);
        bus_item_t it;
        it.kind = 1'b0;
        it.push_byte = b;
        it.bus_status = 8'($urandom_range(0, 255));
        tx_items.push_back(it);
        planned++;
    endtask

    task automatic add_status(logic [7:0] s);
        bus_item_t it;
        it.kind = 1'b1;
        it.push_byte = 8'($urandom_range(0, 255));
        it.bus_status = s;
        tx_items.push_back(it);
        planned++;
    endtask

    function automatic logic [7:0] any_status();
        case ($urandom_range(0, 9))
            0, 1: return 8'($urandom_range(0, 255));
            2: return ST_START;
            3: return ST_RESTART;
            4: return ST_ADDR_ACK;
            default: return ST_DATA_ACK;
        endcase
    endfunction

    task automatic add_frames();
        int nf;
        int lens[3];
        int k;
        int j;
        nf = $urandom_range(1, 3);
        for (k = 0; k < nf; k++) begin
            lens[k] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 4);
            add_push(8'(lens[k]));
            add_push(8'($urandom_range(0, 255)));
            for (j = 0; j < lens[k]; j++)
                add_push(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 19) == 0)
                add_status(any_status());
        end
        for (k = 0; k < nf; k++) begin
            add_status((k == 0) ? ST_START : ST_RESTART);
            add_status(ST_ADDR_ACK);
            for (j = 1; j < lens[k]; j++) begin
                if ($urandom_range(0, 29) == 0)
                    add_status(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 39) == 0)
                    add_push(8'($urandom_range(0, 255)));
                add_status(ST_DATA_ACK);
            end
            // a broken frame now and then skips its closing ack
            if ($urandom_range(0, 9) != 0)
                add_status(ST_DATA_ACK);
        end
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%02h, got 0x%02h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cyc_cnt <= '0;
            hold_left <= 0;
        end
        else begin
            cyc_cnt <= cyc_cnt + 1;
            if (cyc_cnt == HOLD_AT)
                hold_left <= HOLD_LEN;
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_req
        logic      idle_ok;
        bus_item_t nxt;
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.kind <= 1'b0;
            req_ch.push_byte <= '0;
            req_ch.bus_status <= '0;
            tail_phase <= 1'b0;
            gap_left = 0;
        end
        else begin
            idle_ok = !tail_phase && cyc_cnt[8:7] != 2'b11 && hold_left == 0;
            if (req_ch.valid && req_ch.ready) begin
                pending_actions.push_back(next_bus_step(cur_item));
                sent_items++;
            end
            if (!(req_ch.valid && !req_ch.ready)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (idle_ok && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(0, 7);
                    req_ch.valid <= 1'b0;
                end
                else if (tx_items.size() != 0) begin
                    nxt = tx_items.pop_front();
                    cur_item = nxt;
                    req_ch.valid <= 1'b1;
                    req_ch.kind <= nxt.kind;
                    req_ch.push_byte <= nxt.push_byte;
                    req_ch.bus_status <= nxt.bus_status;
                end
                else begin
                    req_ch.valid <= 1'b0;
                end
            end
            tail_phase <= tx_items.size() < TAIL_ITEMS;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch_res
        bus_result_t want;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else begin
            if (res_ch.valid && res_ch.ready) begin
                got_results++;
                if (pending_actions.size() == 0) begin
                    $error("result transfer with nothing expected: action %0d byte 0x%02h",
                           res_ch.bus_action, res_ch.write_byte);
                    fails++;
                end
                else begin
                    want = pending_actions.pop_front();
                    check_field("bus_action", 8'(want.action), 8'(res_ch.bus_action));
                    check_field("write_byte", want.write_byte, res_ch.write_byte);
                    check_field("finished", 8'(want.finished), 8'(res_ch.finished));
                    check_field("queue_fill", 8'(want.queue_fill), 8'(res_ch.queue_fill));
                    check_field("push_dropped", 8'(want.push_dropped), 8'(res_ch.push_dropped));
                    check_field("pop_underflow", 8'(want.pop_underflow),
                                8'(res_ch.pop_underflow));
                    case (want.action)
                        ACT_WRITE: n_writes++;
                        ACT_STOP: n_stops++;
                        ACT_RESTART: n_restarts++;
                        ACT_START: n_starts++;
                        default: ;
                    endcase
                    n_dropped += want.push_dropped;
                    n_underflow += want.pop_underflow;
                end
            end
            if (hold_left != 0) begin
                res_ch.ready <= 1'b0;
            end
            else if (stall_left != 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (!tail_phase && cyc_cnt[8:7] != 2'b01 && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 7);
                res_ch.ready <= 1'b0;
            end
            else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("i2c_master_frame_sequencer_core regression: fail");
        $finish;
    end

    initial begin
        int r;
        int i;
        rst_n = 1'b0;
        rd_ptr = 0;
        wr_ptr = 0;
        fill_cnt = 0;
        frame_len = '0;
        sent_cnt = '0;
        last_sent = '0;
        done_bit = 1'b1;
        planned = 0;
        sent_items = 0;
        got_results = 0;
        fails = 0;
        n_writes = 0;
        n_stops = 0;
        n_restarts = 0;
        n_starts = 0;
        n_dropped = 0;
        n_underflow = 0;

        // two-byte frame through to stop
        add_push(8'h02);
        add_push(8'hA5);
        add_push(8'h00);
        add_push(8'hFF);
        add_status(ST_START);
        add_status(ST_ADDR_ACK);
        add_status(ST_DATA_ACK);
        add_status(ST_DATA_ACK);
        // empty frame followed by a queued frame: restart path
        add_push(8'h00);
        add_push(8'h5A);
        add_push(8'h01);
        add_push(8'h3C);
        add_push(8'h81);
        add_status(ST_START);
        add_status(ST_DATA_ACK);
        add_status(ST_RESTART);
        add_status(ST_ADDR_ACK);
        add_status(ST_DATA_ACK);
        // error codes
        add_status(8'hFF);
        add_status(8'h00);
        // pops from an empty queue, then a frame that claims 255 bytes
        add_status(ST_START);
        add_push(8'hFF);
        add_push(8'h00);
        add_status(ST_START);
        add_status(ST_ADDR_ACK);

        while (planned < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                add_frames();
            end
            else if (r < 80) begin
                for (i = $urandom_range(30, 36); i > 0; i--)
                    add_push(8'($urandom_range(0, 255)));
                for (i = $urandom_range(10, 40); i > 0; i--)
                    add_status(($urandom_range(0, 3) == 0) ? ST_START : ST_DATA_ACK);
            end
            else begin
                for (i = $urandom_range(1, 6); i > 0; i--) begin
                    if ($urandom_range(0, 1))
                        add_push(8'($urandom_range(0, 255)));
                    else
                        add_status(any_status());
                end
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do @(negedge clk); while (tx_items.size() != 0 || req_ch.valid);
        do @(negedge clk); while (pending_actions.size() != 0);
        repeat (8) @(posedge clk);

        $display("covered %0d transfers in, %0d results out: %0d writes, %0d stops, %0d restarts",
                 sent_items, got_results, n_writes, n_stops, n_restarts);
        $display("error restarts %0d, dropped pushes %0d, empty-queue pops %0d",
                 n_starts, n_dropped, n_underflow);
        if (fails == 0)
            $display("i2c_master_frame_sequencer_core regression: pass");
        else
            $display("i2c_master_frame_sequencer_core regression: fail");
        $finish;
    end

endmodule
